// ===== rtl/core/arpbt_pkg.sv =====
// arpbt_pkg: shared types and constants for the arp binding table
// field widths, operation codes, sequencer states, table entry and result types
// used by arpbt_store, arpbt_ctrl and arp_binding_table

package arpbt_pkg;

	localparam int CAPACITY_DEF = 64;

	localparam int OP_W      = 2;
	localparam int IP_W      = 32;
	localparam int MAC_W     = 48;
	localparam int IDX_OUT_W = 6;
	localparam int CNT_OUT_W = 7;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_CHECK  = 2'd1;
	localparam logic [OP_W-1:0] OP_FIND   = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [MAC_W-1:0] mac;
		logic [IP_W-1:0]  ip;
	} entry_t;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_ctl_t;

	typedef struct packed {
		logic                 table_full;
		logic [MAC_W-1:0]     old_mac;
		logic [CNT_OUT_W-1:0] mismatch_count;
		logic                 changed;
		logic [IDX_OUT_W-1:0] match_index;
		logic                 found;
	} result_t;

endpackage

// ===== rtl/core/arpbt_store.sv =====
// arpbt_store: binding memory, one write port and one registered read port
// holds packed ip and mac per entry; uses arpbt_pkg for the entry type

module arpbt_store #(
	parameter int DEPTH = arpbt_pkg::CAPACITY_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                clk,
	input  arpbt_pkg::mem_ctl_t ctl,
	input  logic [AW-1:0]       wr_addr,
	input  arpbt_pkg::entry_t   wr_data,
	input  logic [AW-1:0]       rd_addr,
	output arpbt_pkg::entry_t   rd_data
);

	arpbt_pkg::entry_t mem [DEPTH];
	arpbt_pkg::entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/core/arpbt_ctrl.sv =====
// arpbt_ctrl: operation sequencer, fill count, scan pointer, compare stage and
// result register; drives the memory in arpbt_store, types from arpbt_pkg

module arpbt_ctrl #(
	parameter int CAPACITY = arpbt_pkg::CAPACITY_DEF,
	parameter int AW       = $clog2(CAPACITY),
	parameter int CW       = $clog2(CAPACITY + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [arpbt_pkg::OP_W-1:0]      op,
	input  logic [arpbt_pkg::IP_W-1:0]      ip_address,
	input  logic [arpbt_pkg::MAC_W-1:0]     mac_address,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output arpbt_pkg::result_t              result,
	output arpbt_pkg::mem_ctl_t             mem_ctl,
	output logic [AW-1:0]                   wr_addr,
	output arpbt_pkg::entry_t               wr_data,
	output logic [AW-1:0]                   rd_addr,
	input  arpbt_pkg::entry_t               rd_data
);

	arpbt_pkg::state_t state_q, state_d;

	logic [CW-1:0] cnt_q;
	logic [CW-1:0] ptr_q;
	logic          vld_s1;
	logic [AW-1:0] idx_s1;
	logic          m_tvalid_q;

	logic [arpbt_pkg::OP_W-1:0]  op_q;
	logic [arpbt_pkg::IP_W-1:0]  ip_q;
	logic [arpbt_pkg::MAC_W-1:0] mac_q;

	logic                         found_q;
	logic [AW-1:0]                idx_q;
	logic [CW-1:0]                mm_q;
	logic [arpbt_pkg::MAC_W-1:0]  old_q;
	logic                         full_q;
	arpbt_pkg::result_t           res_q;

	logic    accept;
	logic    has_room;
	logic    out_load;
	logic    hit_ip;
	logic    hit_mac;
	logic [31:0] idx_ext;
	logic [31:0] mm_ext;

	assign accept   = s_tvalid && (state_q == arpbt_pkg::ST_IDLE);
	assign has_room = (cnt_q < CW'(CAPACITY));
	assign out_load = (state_q == arpbt_pkg::ST_DONE) && (!m_tvalid_q || m_tready);
	assign hit_ip   = (rd_data.ip == ip_q);
	assign hit_mac  = (rd_data.mac == mac_q);

	// sequencer: next state and memory strobes
	always_comb begin
		state_d       = state_q;
		mem_ctl.wr_en = 1'b0;
		mem_ctl.rd_en = 1'b0;
		unique case (state_q)
			arpbt_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (op) inside
						arpbt_pkg::OP_INSERT: begin
							mem_ctl.wr_en = has_room;
							state_d       = arpbt_pkg::ST_DONE;
						end
						arpbt_pkg::OP_CHECK, arpbt_pkg::OP_FIND: begin
							state_d = (cnt_q == '0) ? arpbt_pkg::ST_DONE : arpbt_pkg::ST_SCAN;
						end
						default: state_d = arpbt_pkg::ST_DONE;
					endcase
				end
			end
			arpbt_pkg::ST_SCAN: begin
				mem_ctl.rd_en = (ptr_q < cnt_q);
				// last read issued and its data consumed
				if ((ptr_q == cnt_q) && !vld_s1) begin
					state_d = arpbt_pkg::ST_DONE;
				end
			end
			arpbt_pkg::ST_DONE: begin
				if (out_load) begin
					state_d = arpbt_pkg::ST_IDLE;
				end
			end
			default: state_d = arpbt_pkg::ST_IDLE;
		endcase
	end

	assign wr_addr      = cnt_q[AW-1:0];
	assign wr_data.ip   = ip_address;
	assign wr_data.mac  = mac_address;
	assign rd_addr      = ptr_q[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= arpbt_pkg::ST_IDLE;
			cnt_q      <= '0;
			ptr_q      <= '0;
			vld_s1     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= mem_ctl.rd_en;
			if (mem_ctl.wr_en) begin
				cnt_q <= CW'(cnt_q + 1'b1);
			end
			if (accept) begin
				ptr_q <= '0;
			end else if (mem_ctl.rd_en) begin
				ptr_q <= CW'(ptr_q + 1'b1);
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// operands, scan accumulators and result register
	always_ff @(posedge clk) begin
		if (mem_ctl.rd_en) begin
			idx_s1 <= ptr_q[AW-1:0];
		end
		if (accept) begin
			op_q    <= op;
			ip_q    <= ip_address;
			mac_q   <= mac_address;
			found_q <= 1'b0;
			mm_q    <= '0;
			old_q   <= '0;
			full_q  <= (op == arpbt_pkg::OP_INSERT) && !has_room;
			idx_q   <= ((op == arpbt_pkg::OP_INSERT) && has_room) ? cnt_q[AW-1:0] : '0;
		end else if (vld_s1) begin
			if ((op_q == arpbt_pkg::OP_FIND) && hit_ip && hit_mac && !found_q) begin
				found_q <= 1'b1;
				idx_q   <= idx_s1;
			end
			if ((op_q == arpbt_pkg::OP_CHECK) && hit_ip && !hit_mac) begin
				if (mm_q == '0) begin
					old_q <= rd_data.mac;
				end
				mm_q <= CW'(mm_q + 1'b1);
			end
		end
		if (out_load) begin
			res_q.found          <= found_q;
			res_q.match_index    <= idx_ext[arpbt_pkg::IDX_OUT_W-1:0];
			res_q.changed        <= (mm_q != '0);
			res_q.mismatch_count <= mm_ext[arpbt_pkg::CNT_OUT_W-1:0];
			res_q.old_mac        <= old_q;
			res_q.table_full     <= full_q;
		end
	end

	// result fields are cut to their port widths
	assign idx_ext = 32'(idx_q);
	assign mm_ext  = 32'(mm_q);

	assign s_tready = (state_q == arpbt_pkg::ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign result   = res_q;

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("fill count beyond capacity");

	a_rd_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		mem_ctl.rd_en |-> (ptr_q < cnt_q))
		else $error("read of an entry not yet written");

	a_no_wr_scan: assert property (@(posedge clk) disable iff (!arst_n)
		mem_ctl.wr_en |-> (state_q == arpbt_pkg::ST_IDLE) && !vld_s1)
		else $error("write while a scan is in flight");

	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == arpbt_pkg::ST_DONE) && m_tvalid_q && !m_tready
		|=> (state_q == arpbt_pkg::ST_DONE))
		else $error("result dropped while output stalled");

	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == arpbt_pkg::ST_SCAN) |-> (cnt_q != '0))
		else $error("scan started on an empty table");
`endif

endmodule

// ===== rtl/core/arp_binding_table.sv =====
// arp_binding_table: top level, stream ports around the sequencer and memory
// instantiates arpbt_ctrl and arpbt_store, types from arpbt_pkg
//
// usage: one operation per input transfer on the s_ group, op on s_tuser
// (0 insert, 1 check for changed mac, 2 find exact pair). every operation
// gives exactly one result transfer on the m_ group.
// insert writes the entry on acceptance if there is room; check and find
// read the n stored entries one per cycle through the single memory read port
// and skip the scan when the table is empty. the scan over the stored entries
// sets the rate: the next item is taken only once the previous result is
// loaded into the output register.
// reset clears the fill count and all control state; the memory is not
// cleared and needs no pass, entries are read only below the fill count.
// the result sits in an output register: s_tready returns as soon as the
// result is loaded, so the next item is taken while a result waits. if the
// receiver stalls, the next finished result waits in the sequencer and no
// further input is taken until the output register frees up.

module arp_binding_table #(
	parameter int CAPACITY = arpbt_pkg::CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // ip_address[31:0], mac_address[79:32]
	input  logic [1:0]  s_tuser,   // op[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	// found[0], match_index[6:1], changed[7], mismatch_count[14:8],
	// old_mac[62:15], table_full[63]
	output logic [63:0] m_tdata
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	arpbt_pkg::mem_ctl_t mem_ctl;
	arpbt_pkg::entry_t   wr_data;
	arpbt_pkg::entry_t   rd_data;
	arpbt_pkg::result_t  result;
	logic [AW-1:0]       wr_addr;
	logic [AW-1:0]       rd_addr;

	arpbt_ctrl #(
		.CAPACITY (CAPACITY),
		.AW       (AW),
		.CW       (CW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.op          (s_tuser),
		.ip_address  (s_tdata[31:0]),
		.mac_address (s_tdata[79:32]),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.result      (result),
		.mem_ctl     (mem_ctl),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data)
	);

	arpbt_store #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.ctl     (mem_ctl),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign m_tdata[0]     = result.found;
	assign m_tdata[6:1]   = result.match_index;
	assign m_tdata[7]     = result.changed;
	assign m_tdata[14:8]  = result.mismatch_count;
	assign m_tdata[62:15] = result.old_mac;
	assign m_tdata[63]    = result.table_full;

endmodule

// ===== sim/arp_binding_table_tb.sv =====
// arp_binding_table_tb: self-checking bench for the arp binding table
// drives insert, check and find requests with random stalls on both stream sides
// and compares each result against a mirror of the table; needs arpbt_pkg and the rtl

module arp_binding_table_tb;

	localparam int TABLE_DEPTH = arpbt_pkg::CAPACITY_DEF;
	localparam logic [arpbt_pkg::OP_W-1:0] OP_UNDEFINED = 2'd3;
	localparam int CYCLE_LIMIT = 600000;
	localparam int HOLD_CYCLES = 500;

	class arp_table_mirror;
		logic [arpbt_pkg::IP_W-1:0]  ip_store[TABLE_DEPTH];
		logic [arpbt_pkg::MAC_W-1:0] mac_store[TABLE_DEPTH];
		int                          entry_count;
		arpbt_pkg::result_t          answers_due[$];
		int                          errors;
		int                          answers_seen;
		int                          stored;
		int                          refused;
		int                          hits;
		int                          changes;

		// works out the table's answer to one accepted request
		function void apply_request(logic [arpbt_pkg::OP_W-1:0] op,
				logic [arpbt_pkg::IP_W-1:0] ip, logic [arpbt_pkg::MAC_W-1:0] mac);
			arpbt_pkg::result_t r;
			r = '0;
			case (op)
				arpbt_pkg::OP_INSERT: begin
					if (entry_count < TABLE_DEPTH) begin
						ip_store[entry_count] = ip;
						mac_store[entry_count] = mac;
						r.match_index = arpbt_pkg::IDX_OUT_W'(entry_count);
						entry_count++;
						stored++;
					end else begin
						r.table_full = 1'b1;
						refused++;
					end
				end
				arpbt_pkg::OP_CHECK: begin
					for (int i = 0; i < entry_count; i++) begin
						if (ip_store[i] == ip && mac_store[i] != mac) begin
							if (r.mismatch_count == 0)
								r.old_mac = mac_store[i];
							r.mismatch_count = r.mismatch_count + 1'b1;
						end
					end
					r.changed = (r.mismatch_count != 0);
					if (r.changed)
						changes++;
				end
				arpbt_pkg::OP_FIND: begin
					for (int i = 0; i < entry_count; i++) begin
						if (!r.found && ip_store[i] == ip && mac_store[i] == mac) begin
							r.found = 1'b1;
							r.match_index = arpbt_pkg::IDX_OUT_W'(i);
						end
					end
					if (r.found)
						hits++;
				end
				default: ;
			endcase
			answers_due.push_back(r);
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] seen);
			if (seen !== want) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
				errors++;
			end
		endfunction

		function void check_answer(arpbt_pkg::result_t got);
			arpbt_pkg::result_t want;
			if (answers_due.size() == 0) begin
				$display("%0t: unexpected result transfer, expected none, actual %h", $time, got);
				errors++;
				return;
			end
			want = answers_due.pop_front();
			answers_seen++;
			compare_field("found", 64'(want.found), 64'(got.found));
			compare_field("match_index", 64'(want.match_index), 64'(got.match_index));
			compare_field("changed", 64'(want.changed), 64'(got.changed));
			compare_field("mismatch_count", 64'(want.mismatch_count),
				64'(got.mismatch_count));
			compare_field("old_mac", 64'(want.old_mac), 64'(got.old_mac));
			compare_field("table_full", 64'(want.table_full), 64'(got.table_full));
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [79:0] s_tdata;   // ip_address[31:0], mac_address[79:32]
	logic [1:0]  s_tuser;   // op[1:0]
	logic        m_tvalid;
	logic        m_tready;
	// found[0], match_index[6:1], changed[7], mismatch_count[14:8],
	// old_mac[62:15], table_full[63]
	logic [63:0] m_tdata;

	arp_table_mirror             mirror;
	int                          sender_idle_pct;
	int                          receiver_idle_pct;
	bit                          hold_off_req;
	int                          cycle_count;
	logic [arpbt_pkg::IP_W-1:0]  ip_pool[4];
	logic [arpbt_pkg::MAC_W-1:0] mac_pool[4];

	arp_binding_table dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// receiver side: random stalls, or one long hold-off on request
	initial begin
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= receiver_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			mirror.check_answer(arpbt_pkg::result_t'(m_tdata));
	end

	initial begin
		cycle_count = 0;
		while (cycle_count <= CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
			mirror.answers_due.size());
		$display("TEST FAILED");
		$finish;
	end

	// valid stays high from one transfer to the next unless an idle cycle is rolled
	task automatic send_item(logic [arpbt_pkg::OP_W-1:0] op, logic [arpbt_pkg::IP_W-1:0] ip,
			logic [arpbt_pkg::MAC_W-1:0] mac);
		if ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {mac, ip};
		do @(posedge clk); while (!s_tready);
		mirror.apply_request(op, ip, mac);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (mirror.answers_due.size() != 0);
	endtask

	// mostly addresses already in the table or from small pools, so checks and finds hit
	task automatic run_random(int count);
		int                          done;
		int                          r;
		int                          k;
		logic [arpbt_pkg::OP_W-1:0]  op;
		logic [arpbt_pkg::IP_W-1:0]  ip;
		logic [arpbt_pkg::MAC_W-1:0] mac;
		done = 0;
		while (done < count) begin
			r = $urandom_range(99);
			if (r < 15)
				op = arpbt_pkg::OP_INSERT;
			else if (r < 55)
				op = arpbt_pkg::OP_CHECK;
			else if (r < 95)
				op = arpbt_pkg::OP_FIND;
			else
				op = OP_UNDEFINED;
			r = $urandom_range(99);
			if (mirror.entry_count > 0 && r < 50) begin
				k = $urandom_range(mirror.entry_count - 1);
				ip = mirror.ip_store[k];
				mac = $urandom_range(1) ? mirror.mac_store[k] : mac_pool[$urandom_range(3)];
			end else if (r < 85) begin
				ip = ip_pool[$urandom_range(3)];
				mac = mac_pool[$urandom_range(3)];
			end else begin
				ip = $urandom;
				mac = arpbt_pkg::MAC_W'({$urandom, $urandom});
			end
			send_item(op, ip, mac);
			if (op != OP_UNDEFINED)
				done++;
		end
	endtask

	initial begin
		mirror = new();
		sender_idle_pct = 36;
		receiver_idle_pct = 64;
		hold_off_req = 1'b0;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= arpbt_pkg::OP_INSERT;
		for (int i = 0; i < 4; i++) begin
			ip_pool[i] = $urandom;
			mac_pool[i] = arpbt_pkg::MAC_W'({$urandom, $urandom});
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// lookups on an empty table and an undefined op
		send_item(arpbt_pkg::OP_FIND, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
		send_item(arpbt_pkg::OP_CHECK, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
		send_item(OP_UNDEFINED, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
		// extreme bindings, then hits and misses on them
		send_item(arpbt_pkg::OP_INSERT, 32'h0, 48'h0);
		send_item(arpbt_pkg::OP_INSERT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
		send_item(arpbt_pkg::OP_FIND, 32'h0, 48'h0);
		send_item(arpbt_pkg::OP_FIND, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
		send_item(arpbt_pkg::OP_FIND, 32'h0, 48'hFFFF_FFFF_FFFF);
		send_item(arpbt_pkg::OP_CHECK, 32'h0, 48'h0);
		send_item(arpbt_pkg::OP_CHECK, 32'h0, 48'hFFFF_FFFF_FFFF);
		// same ip under several macs, duplicate pair
		send_item(arpbt_pkg::OP_INSERT, 32'h0, 48'h5555_5555_5555);
		send_item(arpbt_pkg::OP_INSERT, 32'h0, 48'h0);
		send_item(arpbt_pkg::OP_FIND, 32'h0, 48'h0);
		send_item(arpbt_pkg::OP_CHECK, 32'h0, 48'hAAAA_AAAA_AAAA);
		send_item(arpbt_pkg::OP_CHECK, 32'h0, 48'h5555_5555_5555);
		send_item(OP_UNDEFINED, 32'h0, 48'h0);
		send_item(arpbt_pkg::OP_INSERT, 32'hA5A5_A5A5, 48'h5A5A_5A5A_5A5A);
		send_item(arpbt_pkg::OP_FIND, 32'hA5A5_A5A5, 48'h5A5A_5A5A_5A5A);
		send_item(arpbt_pkg::OP_CHECK, 32'h1234_5678, 48'h0);
		wait_drained();

		run_random(345);
		wait_drained();

		sender_idle_pct = 64;
		receiver_idle_pct = 36;
		run_random(345);
		wait_drained();

		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		hold_off_req = 1'b1;
		run_random(340);

		wait_drained();
		repeat (TABLE_DEPTH + 8) @(posedge clk);

		$display("checked %0d results: %0d bindings stored, %0d inserts refused on a full table,",
			mirror.answers_seen, mirror.stored, mirror.refused);
		$display("%0d exact-pair hits, %0d changed-mac reports, %0d mismatches",
			mirror.hits, mirror.changes, mirror.errors);
		if (mirror.errors == 0 && mirror.answers_due.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
